// ----- rtl/core/occupancy_grid_path_search_macros.svh -----
// assertion macros for the grid path search block
`ifndef OCCUPANCY_GRID_PATH_SEARCH_MACROS_SVH
`define OCCUPANCY_GRID_PATH_SEARCH_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every clock once out of reset
`define OGPS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ogps check failed");
// next-cycle implication
`define OGPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ogps check failed");
`else
`define OGPS_ASSERT_SAME(lbl, ante, cons)
`define OGPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/ogps_pkg.sv -----
// shared constants, codes and types of the grid path search block
package ogps_pkg;
	localparam int OGPS_MAX_ROWS    = 64;
	localparam int OGPS_MAX_COLS    = 64;
	localparam int OGPS_QUEUE_DEPTH = 8192;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int DIM_W      = 7;
	localparam int STEP_W     = 16;
	localparam int COST_W     = 24;
	localparam logic [COST_W-1:0] COST_MAX = 24'hFFFFFF;

	// function codes
	localparam logic [1:0] FN_WRITE  = 2'd0;
	localparam logic [1:0] FN_SEARCH = 2'd1;
	localparam logic [1:0] FN_READ   = 2'd2;
	localparam logic [1:0] FN_NONE   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOPATH = 2'd1;
	localparam logic [1:0] ST_OVF    = 2'd2;
	localparam logic [1:0] ST_RANGE  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COSTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COSTV = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COSTD = 3'd4;

	typedef struct packed {
		logic [DIM_W-1:0]  num_rows;
		logic [DIM_W-1:0]  num_cols;
		logic [STEP_W-1:0] cost_horizontal;
		logic [STEP_W-1:0] cost_vertical;
		logic [STEP_W-1:0] cost_diagonal;
	} cfg_t;

	// neighbor slot 0..8 of the 3x3 window: {row select, column select}
	function automatic logic [3:0] nbr_sel(input logic [3:0] k);
		logic [3:0] r;
		case (k)
			4'd0: r = {2'd0, 2'd0};
			4'd1: r = {2'd0, 2'd1};
			4'd2: r = {2'd0, 2'd2};
			4'd3: r = {2'd1, 2'd0};
			4'd4: r = {2'd1, 2'd1};
			4'd5: r = {2'd1, 2'd2};
			4'd6: r = {2'd2, 2'd0};
			4'd7: r = {2'd2, 2'd1};
			4'd8: r = {2'd2, 2'd2};
			default: r = {2'd1, 2'd1};
		endcase
		return r;
	endfunction
endpackage

// ----- rtl/core/ogps_if.sv -----
// handshake channels of the grid path search block
interface ogps_cmd_if import ogps_pkg::*; #(
	parameter int RB = 6,
	parameter int CB = 6,
	parameter int AW = 12
);
	logic          valid;
	logic          ready;
	logic [1:0]    func;
	logic [RB-1:0] row;
	logic [CB-1:0] col;
	logic          blocked;
	logic [RB-1:0] goal_row;
	logic [CB-1:0] goal_col;
	logic [AW-1:0] path_index;
	modport source(output valid, func, row, col, blocked, goal_row, goal_col, path_index,
		input ready);
	modport sink(input valid, func, row, col, blocked, goal_row, goal_col, path_index,
		output ready);
endinterface

interface ogps_rsp_if import ogps_pkg::*; #(
	parameter int RB = 6,
	parameter int CB = 6,
	parameter int LW = 13
);
	logic          valid;
	logic          ready;
	logic [1:0]    status;
	logic [LW-1:0] path_len;
	logic [RB-1:0] cell_row;
	logic [CB-1:0] cell_col;
	modport source(output valid, status, path_len, cell_row, cell_col, input ready);
	modport sink(input valid, status, path_len, cell_row, cell_col, output ready);
endinterface

interface ogps_cfg_if import ogps_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/ogps_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
module ogps_ram #(
	parameter int W = 1,
	parameter int D = 2
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/ogps_engine.sv -----
// command sequencer: grid writes, search walk, path build and path reads over rams
module ogps_engine import ogps_pkg::*; #(
	parameter int MAX_ROWS    = OGPS_MAX_ROWS,
	parameter int MAX_COLS    = OGPS_MAX_COLS,
	parameter int QUEUE_DEPTH = OGPS_QUEUE_DEPTH,
	localparam int CELLS = MAX_ROWS * MAX_COLS,
	localparam int RB    = $clog2(MAX_ROWS),
	localparam int CB    = $clog2(MAX_COLS),
	localparam int AW    = $clog2(CELLS),
	localparam int LW    = $clog2(CELLS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          go,
	input  logic [1:0]    func,
	input  logic [RB-1:0] row,
	input  logic [CB-1:0] col,
	input  logic          blocked,
	input  logic [RB-1:0] goal_row,
	input  logic [CB-1:0] goal_col,
	input  logic [AW-1:0] path_index,
	input  logic          take,
	output logic          idle,
	output logic          res_valid,
	output logic [1:0]    status,
	output logic [LW-1:0] path_len,
	output logic [RB-1:0] cell_row,
	output logic [CB-1:0] cell_col
);
	localparam int NW  = RB + CB;
	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW  = COST_W + NW;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RDP   = 4'd2;
	localparam logic [3:0] S_SWEEP = 4'd3;
	localparam logic [3:0] S_INIT  = 4'd4;
	localparam logic [3:0] S_DEQ   = 4'd5;
	localparam logic [3:0] S_DEQW  = 4'd6;
	localparam logic [3:0] S_CUR   = 4'd7;
	localparam logic [3:0] S_OCC   = 4'd8;
	localparam logic [3:0] S_NSEL  = 4'd9;
	localparam logic [3:0] S_NWR   = 4'd10;
	localparam logic [3:0] S_PCHK  = 4'd11;
	localparam logic [3:0] S_PWAIT = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	localparam logic [3:0] K_LAST = 4'd9;

	function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] p);
		return AW'(int'(p[NW-1:CB]) * MAX_COLS + int'(p[CB-1:0]));
	endfunction

	logic [3:0]        state_q;
	logic [AW-1:0]     clr_q;
	logic [NW-1:0]     start_q, goal_q, cur_q, nb_q, node_q;
	logic [COST_W-1:0] curcost_q, nd_q;
	logic [QAW-1:0]    head_q, tail_q;
	logic [QCW-1:0]    cnt_q;
	logic [3:0]        k_q;
	logic [8:0]        occ_q;
	logic              pinb_q;
	logic [LW-1:0]     len_q, plen_q, area_q;
	logic [1:0]        status_q;
	logic [RB-1:0]     rrow_q;
	logic [CB-1:0]     rcol_q;

	logic          occ_we, occ_wd, occ_rd;
	logic [AW-1:0] occ_wa, occ_ra;
	logic          cost_we;
	logic [AW-1:0] cost_wa, cost_ra;
	logic [CW-1:0] cost_wd, cost_rd;
	logic          q_we;
	logic [QAW-1:0] q_wa, q_ra;
	logic [NW-1:0] q_wd, q_rd;
	logic          p_we;
	logic [AW-1:0] p_wa, p_ra;
	logic [NW-1:0] p_wd, p_rd;

	logic [RB:0]   rows_u, nr_x;
	logic [CB:0]   cols_u, nc_x;
	logic [3:0]    sel;
	logic          nb_inb;
	logic [NW-1:0] nb_cell;
	logic [8:0]    pass;
	logic [STEP_W-1:0] step;
	logic [COST_W:0]   sum;
	logic [COST_W-1:0] nd;
	logic          start_ok, goal_ok, relax, q_full;
	logic [QAW-1:0] head_nx, tail_nx;

	// grid size in use, clamped to the physical grid, a zero size taken as one
	always_comb begin
		if (cfg.num_rows == '0) begin
			rows_u = (RB+1)'(1);
		end else if (int'(cfg.num_rows) > MAX_ROWS) begin
			rows_u = (RB+1)'(MAX_ROWS);
		end else begin
			rows_u = (RB+1)'(cfg.num_rows);
		end
		if (cfg.num_cols == '0) begin
			cols_u = (CB+1)'(1);
		end else if (int'(cfg.num_cols) > MAX_COLS) begin
			cols_u = (CB+1)'(MAX_COLS);
		end else begin
			cols_u = (CB+1)'(cfg.num_cols);
		end
	end

	// neighbor under k_q; an underflow wraps high and fails the bounds test
	assign sel     = nbr_sel(k_q);
	assign nr_x    = {1'b0, cur_q[NW-1:CB]} + (RB+1)'(sel[3:2]) - (RB+1)'(1);
	assign nc_x    = {1'b0, cur_q[CB-1:0]} + (CB+1)'(sel[1:0]) - (CB+1)'(1);
	assign nb_inb  = (nr_x < rows_u) && (nc_x < cols_u);
	assign nb_cell = {nr_x[RB-1:0], nc_x[CB-1:0]};

	// occ_q holds the 3x3 window, off-grid cells read as blocked;
	// diagonals also need both orthogonal cells beside them free
	assign pass[0] = !occ_q[0] && !occ_q[1] && !occ_q[3];
	assign pass[1] = !occ_q[1];
	assign pass[2] = !occ_q[2] && !occ_q[1] && !occ_q[5];
	assign pass[3] = !occ_q[3];
	assign pass[4] = 1'b0;
	assign pass[5] = !occ_q[5];
	assign pass[6] = !occ_q[6] && !occ_q[7] && !occ_q[3];
	assign pass[7] = !occ_q[7];
	assign pass[8] = !occ_q[8] && !occ_q[7] && !occ_q[5];

	always_comb begin
		if (k_q inside {4'd1, 4'd7}) begin
			step = cfg.cost_vertical;
		end else if (k_q inside {4'd3, 4'd5}) begin
			step = cfg.cost_horizontal;
		end else begin
			step = cfg.cost_diagonal;
		end
	end

	assign sum   = {1'b0, curcost_q} + (COST_W+1)'(step);
	assign nd    = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
	assign relax = nd_q < cost_rd[CW-1:NW];
	assign q_full = cnt_q == QCW'(QUEUE_DEPTH);

	assign start_ok = ({1'b0, row} < rows_u) && ({1'b0, col} < cols_u);
	assign goal_ok  = ({1'b0, goal_row} < rows_u) && ({1'b0, goal_col} < cols_u);

	assign head_nx = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);
	assign tail_nx = (tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QAW'(1);

	// ram port control
	always_comb begin
		occ_we  = 1'b0;
		occ_wa  = addr_of({row, col});
		occ_wd  = blocked;
		occ_ra  = nb_inb ? addr_of(nb_cell) : '0;
		cost_we = 1'b0;
		cost_wa = addr_of(nb_q);
		cost_wd = {nd_q, cur_q};
		cost_ra = addr_of(nb_cell);
		q_we    = 1'b0;
		q_wa    = tail_q;
		q_wd    = nb_q;
		q_ra    = head_q;
		p_we    = 1'b0;
		p_wa    = plen_q[AW-1:0];
		p_wd    = node_q;
		p_ra    = path_index;
		case (state_q)
			S_CLR: begin
				occ_we = 1'b1;
				occ_wa = clr_q;
				occ_wd = 1'b0;
			end
			S_IDLE: begin
				occ_we = go && (func == FN_WRITE) && start_ok;
			end
			S_SWEEP: begin
				cost_we = 1'b1;
				cost_wa = clr_q;
				cost_wd = {COST_MAX, NW'(0)};
			end
			S_INIT: begin
				cost_we = 1'b1;
				cost_wa = addr_of(start_q);
				cost_wd = '0;
				q_we    = 1'b1;
				q_wa    = '0;
				q_wd    = start_q;
			end
			S_DEQW: begin
				cost_ra = addr_of(q_rd);
			end
			S_NWR: begin
				cost_we = relax;
				q_we    = relax && !q_full;
			end
			S_PCHK: begin
				p_we    = plen_q < area_q;
				cost_ra = addr_of(node_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			len_q    <= '0;
			status_q <= ST_OK;
			k_q      <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (go) begin
						rrow_q   <= '0;
						rcol_q   <= '0;
						status_q <= ST_RANGE;
						state_q  <= S_DONE;
						case (func)
							FN_WRITE: begin
								if (start_ok) begin
									status_q <= ST_OK;
								end
							end
							FN_SEARCH: begin
								if (start_ok && goal_ok) begin
									start_q <= {row, col};
									goal_q  <= {goal_row, goal_col};
									clr_q   <= '0;
									state_q <= S_SWEEP;
								end
							end
							FN_READ: begin
								if (LW'(path_index) < len_q) begin
									state_q <= S_RDP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RDP: begin
					rrow_q   <= p_rd[NW-1:CB];
					rcol_q   <= p_rd[CB-1:0];
					status_q <= ST_OK;
					state_q  <= S_DONE;
				end
				S_SWEEP: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					head_q  <= '0;
					tail_q  <= (QUEUE_DEPTH == 1) ? '0 : QAW'(1);
					cnt_q   <= QCW'(1);
					area_q  <= LW'(int'(rows_u) * int'(cols_u));
					state_q <= S_DEQ;
				end
				S_DEQ: begin
					if (cnt_q == '0) begin
						status_q <= ST_NOPATH;
						len_q    <= '0;
						state_q  <= S_DONE;
					end else begin
						head_q  <= head_nx;
						cnt_q   <= cnt_q - QCW'(1);
						state_q <= S_DEQW;
					end
				end
				S_DEQW: begin
					cur_q <= q_rd;
					if (q_rd == goal_q) begin
						node_q  <= goal_q;
						plen_q  <= '0;
						state_q <= S_PCHK;
					end else begin
						state_q <= S_CUR;
					end
				end
				S_CUR: begin
					curcost_q <= cost_rd[CW-1:NW];
					k_q       <= '0;
					state_q   <= S_OCC;
				end
				S_OCC: begin
					// read issued for slot k_q, data of slot k_q-1 shifts in
					pinb_q <= nb_inb;
					if (k_q != '0) begin
						occ_q <= {!pinb_q || occ_rd, occ_q[8:1]};
					end
					if (k_q == K_LAST) begin
						k_q     <= '0;
						state_q <= S_NSEL;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_NSEL: begin
					if (k_q == K_LAST) begin
						state_q <= S_DEQ;
					end else begin
						k_q <= k_q + 4'd1;
						if (pass[k_q]) begin
							nb_q    <= nb_cell;
							nd_q    <= nd;
							state_q <= S_NWR;
						end
					end
				end
				S_NWR: begin
					state_q <= S_NSEL;
					if (relax) begin
						if (q_full) begin
							status_q <= ST_OVF;
							len_q    <= '0;
							state_q  <= S_DONE;
						end else begin
							tail_q <= tail_nx;
							cnt_q  <= cnt_q + QCW'(1);
						end
					end
				end
				S_PCHK: begin
					if (plen_q >= area_q) begin
						status_q <= ST_NOPATH;
						len_q    <= '0;
						state_q  <= S_DONE;
					end else begin
						plen_q <= plen_q + LW'(1);
						if (node_q == start_q) begin
							status_q <= ST_OK;
							len_q    <= plen_q + LW'(1);
							state_q  <= S_DONE;
						end else begin
							state_q <= S_PWAIT;
						end
					end
				end
				S_PWAIT: begin
					node_q  <= cost_rd[NW-1:0];
					state_q <= S_PCHK;
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	ogps_ram #(.W(1), .D(CELLS)) u_occ_ram (
		.clk(clk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd), .raddr(occ_ra), .rdata(occ_rd)
	);
	ogps_ram #(.W(CW), .D(CELLS)) u_cost_ram (
		.clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd), .raddr(cost_ra),
		.rdata(cost_rd)
	);
	ogps_ram #(.W(NW), .D(QUEUE_DEPTH)) u_queue_ram (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
	);
	ogps_ram #(.W(NW), .D(CELLS)) u_path_ram (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
	);

	assign idle      = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign status    = status_q;
	assign path_len  = len_q;
	assign cell_row  = rrow_q;
	assign cell_col  = rcol_q;
endmodule

// ----- rtl/core/occupancy_grid_path_search.sv -----
// top level of the grid path search block: config registers, engine, result register
//  channel | dir | beat carries
//  cmd     | in  | func, row, col, blocked, goal_row, goal_col, path_index
//  rsp     | out | status, path_len, cell_row, cell_col
//  cfg     | in  | index, data (register write, always ready)
// cell write, rejected command: straight to result; path read: via a path ram read
// search: sweep of all CELLS cost ram entries, then per dequeued cell a 3x3 window
// occupancy read and a cost ram read-modify-write per open neighbor; path build
// walks back goal to start; after reset cmd.ready stays low while the grid clears
// a result waits in the output register under stall while the next command is taken
`include "occupancy_grid_path_search_macros.svh"
module occupancy_grid_path_search import ogps_pkg::*; #(
	parameter int MAX_ROWS    = OGPS_MAX_ROWS,
	parameter int MAX_COLS    = OGPS_MAX_COLS,
	parameter int QUEUE_DEPTH = OGPS_QUEUE_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	ogps_cmd_if.sink  cmd,
	ogps_rsp_if.source rsp,
	ogps_cfg_if.sink  cfg
);
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int RB    = $clog2(MAX_ROWS);
	localparam int CB    = $clog2(MAX_COLS);
	localparam int LW    = $clog2(CELLS + 1);

	cfg_t          cfg_q;
	logic          go, take, eng_idle, eng_res_valid;
	logic [1:0]    eng_status;
	logic [LW-1:0] eng_len;
	logic [RB-1:0] eng_row;
	logic [CB-1:0] eng_col;
	logic          rsp_valid_q;
	logic [1:0]    rsp_status_q;
	logic [LW-1:0] rsp_len_q;
	logic [RB-1:0] rsp_row_q;
	logic [CB-1:0] rsp_col_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_rows        <= DIM_W'(64);
			cfg_q.num_cols        <= DIM_W'(64);
			cfg_q.cost_horizontal <= STEP_W'(256);
			cfg_q.cost_vertical   <= STEP_W'(256);
			cfg_q.cost_diagonal   <= STEP_W'(362);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ROWS:  cfg_q.num_rows        <= cfg.data[DIM_W-1:0];
				REG_COLS:  cfg_q.num_cols        <= cfg.data[DIM_W-1:0];
				REG_COSTH: cfg_q.cost_horizontal <= cfg.data[STEP_W-1:0];
				REG_COSTV: cfg_q.cost_vertical   <= cfg.data[STEP_W-1:0];
				REG_COSTD: cfg_q.cost_diagonal   <= cfg.data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cmd.ready = eng_idle;
	assign go        = cmd.valid && eng_idle;
	assign take      = !rsp_valid_q || rsp.ready;

	ogps_engine #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .QUEUE_DEPTH(QUEUE_DEPTH)
	) u_engine (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .go(go), .func(cmd.func),
		.row(cmd.row), .col(cmd.col), .blocked(cmd.blocked), .goal_row(cmd.goal_row),
		.goal_col(cmd.goal_col), .path_index(cmd.path_index), .take(take),
		.idle(eng_idle), .res_valid(eng_res_valid), .status(eng_status),
		.path_len(eng_len), .cell_row(eng_row), .cell_col(eng_col)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= eng_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && eng_res_valid) begin
			rsp_status_q <= eng_status;
			rsp_len_q    <= eng_len;
			rsp_row_q    <= eng_row;
			rsp_col_q    <= eng_col;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.path_len = rsp_len_q;
	assign rsp.cell_row = rsp_row_q;
	assign rsp.cell_col = rsp_col_q;

	`OGPS_ASSERT_NEXT(a_result_lands, eng_res_valid && take, rsp_valid_q)
	`OGPS_ASSERT_NEXT(a_go_leaves_idle, go, !eng_idle)
	`OGPS_ASSERT_SAME(a_idle_no_result, eng_idle, !eng_res_valid)
endmodule
